// ----- src/mvdi_pkg.sv -----
// Package for the mesh vertex dedup indexer: field widths, vertex and result
// types and the sequencer state type. No dependencies.
package mvdi_pkg;

  localparam int unsigned COORD_W         = 32;
  localparam int unsigned IDX_OUT_W       = 10;
  localparam int unsigned CORNER_W        = 2;
  localparam int unsigned TABLE_DEPTH_DEF = 1024;

  localparam logic [CORNER_W-1:0] CORNER_FIRST = 2'd0;
  localparam logic [CORNER_W-1:0] CORNER_LAST  = 2'd2;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
  } vertex_t;

  typedef struct packed {
    logic [IDX_OUT_W-1:0] vertex_index;
    logic                 is_new;
    logic [CORNER_W-1:0]  corner;
    logic                 triangle_done;
    logic                 table_full;
  } result_t;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_SCAN,
    SEQ_DONE
  } seq_state_e;

endpackage

// ----- src/mvdi_table.sv -----
// Vertex table storage: one write port and one registered read port.
// Depends on mvdi_pkg for the vertex type.
module mvdi_table
  import mvdi_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF,
  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH)
) (
  input  logic             clk_i,
  input  logic             rd_en_i,
  input  logic [IDX_W-1:0] rd_addr_i,
  output vertex_t          rd_data_o,
  input  logic             wr_en_i,
  input  logic [IDX_W-1:0] wr_addr_i,
  input  vertex_t          wr_data_i
);

  vertex_t mem [TABLE_DEPTH];
  vertex_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- src/mvdi_seq.sv -----
// Scan sequencer: holds the request vertex, walks the table one entry per cycle
// through the shared comparator, appends misses and tracks the corner count.
// Depends on mvdi_pkg.
module mvdi_seq
  import mvdi_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF,
  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH),
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  vertex_t          in_vertex_i,
  output logic             rd_en_o,
  output logic [IDX_W-1:0] rd_addr_o,
  input  vertex_t          rd_data_i,
  output logic             wr_en_o,
  output logic [IDX_W-1:0] wr_addr_o,
  output vertex_t          wr_data_o,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output result_t          res_o
);

  seq_state_e          state_q, state_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [CNT_W-1:0]    issue_q, issue_d;
  logic                cmp_vld_q, cmp_vld_d;
  logic [IDX_W-1:0]    cmp_idx_q, cmp_idx_d;
  logic                hit_q, hit_d;
  logic [IDX_W-1:0]    hit_idx_q, hit_idx_d;
  logic [CORNER_W-1:0] corner_q, corner_d;
  vertex_t             vertex_q, vertex_d;

  logic                match;
  logic                room;
  logic [IDX_W-1:0]    res_idx;
  logic [IDX_W+IDX_OUT_W-1:0] res_idx_ext;

  assign match = cmp_vld_q && (rd_data_i == vertex_q);
  assign room  = count_q < CNT_W'(TABLE_DEPTH);
  assign res_idx_ext = {{IDX_OUT_W{1'b0}}, res_idx};

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    issue_d   = issue_q;
    cmp_vld_d = 1'b0;
    cmp_idx_d = cmp_idx_q;
    hit_d     = hit_q;
    hit_idx_d = hit_idx_q;
    corner_d  = corner_q;
    vertex_d  = vertex_q;
    in_ready_o  = 1'b0;
    rd_en_o     = 1'b0;
    rd_addr_o   = issue_q[IDX_W-1:0];
    wr_en_o     = 1'b0;
    wr_addr_o   = count_q[IDX_W-1:0];
    wr_data_o   = vertex_q;
    res_valid_o = 1'b0;
    res_idx     = hit_idx_q;
    if (!hit_q) begin
      res_idx = room ? count_q[IDX_W-1:0] : IDX_W'(TABLE_DEPTH - 1);
    end
    res_o.vertex_index  = res_idx_ext[IDX_OUT_W-1:0];
    res_o.is_new        = !hit_q && room;
    res_o.corner        = corner_q;
    res_o.triangle_done = corner_q == CORNER_LAST;
    res_o.table_full    = !hit_q && !room;

    case (state_q)
      SEQ_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          vertex_d = in_vertex_i;
          issue_d  = '0;
          hit_d    = 1'b0;
          state_d  = SEQ_SCAN;
        end
      end
      SEQ_SCAN: begin
        if (match) begin
          hit_d     = 1'b1;
          hit_idx_d = cmp_idx_q;
          state_d   = SEQ_DONE;
        end else if (issue_q < count_q) begin
          rd_en_o   = 1'b1;
          cmp_vld_d = 1'b1;
          cmp_idx_d = issue_q[IDX_W-1:0];
          issue_d   = issue_q + 1'b1;
        end else if (!cmp_vld_q) begin
          state_d = SEQ_DONE;
        end
      end
      SEQ_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          if (!hit_q && room) begin
            wr_en_o = 1'b1;
            count_d = count_q + 1'b1;
          end
          corner_d = (corner_q >= CORNER_LAST) ? CORNER_FIRST : corner_q + 1'b1;
          state_d  = SEQ_IDLE;
        end
      end
      default: begin
        state_d = SEQ_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= SEQ_IDLE;
      count_q   <= '0;
      issue_q   <= '0;
      cmp_vld_q <= 1'b0;
      hit_q     <= 1'b0;
      corner_q  <= CORNER_FIRST;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      issue_q   <= issue_d;
      cmp_vld_q <= cmp_vld_d;
      hit_q     <= hit_d;
      corner_q  <= corner_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q <= cmp_idx_d;
    hit_idx_q <= hit_idx_d;
    vertex_q  <= vertex_d;
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(TABLE_DEPTH))
    else $error("vertex count exceeds table depth");

  a_write_on_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en_o |-> (state_q == SEQ_DONE) && res_ready_i && !hit_q)
    else $error("table written outside a committed miss");

  a_idle_no_compare: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SEQ_IDLE) |-> !cmp_vld_q)
    else $error("compare pending while idle");

  a_new_bumps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_ready_i && res_o.is_new) |=> count_q == $past(count_q) + 1'b1)
    else $error("new vertex did not advance the count");

  a_new_full_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> !(res_o.is_new && res_o.table_full))
    else $error("result both new and full");

endmodule

// ----- src/mesh_vertex_dedup_indexer.sv -----
// Top level of the mesh vertex dedup indexer: scan sequencer, vertex table and
// result output register. Depends on mvdi_pkg, mvdi_seq and mvdi_table.
//
//   Channel  Handshake               Payload
//   in       in_valid_i/in_ready_o   coord_x_i, coord_y_i, coord_z_i
//   out      out_valid_o/out_ready_i vertex_index_o, is_new_o, corner_o,
//                                    triangle_done_o, table_full_o
//
// A request is taken while the sequencer is idle; the table is then scanned from
// entry 0 until a match or the end of the filled entries, and the result waits
// until the output register takes it before the next request is accepted.
// The scan time is set by the single table read port, scanned one entry a cycle.
// Reset empties the table at once by clearing the entry count and the corner.
// A result waiting in the output register does not block the next request;
// only a finished scan waits there until the register is free.
module mesh_vertex_dedup_indexer
  import mvdi_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF,
  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [COORD_W-1:0]   coord_x_i,
  input  logic [COORD_W-1:0]   coord_y_i,
  input  logic [COORD_W-1:0]   coord_z_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [IDX_OUT_W-1:0] vertex_index_o,
  output logic                 is_new_o,
  output logic [CORNER_W-1:0]  corner_o,
  output logic                 triangle_done_o,
  output logic                 table_full_o
);

  vertex_t          in_vertex;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  vertex_t          rd_data;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  vertex_t          wr_data;
  logic             res_valid;
  logic             res_ready;
  result_t          res;

  logic    out_valid_q, out_valid_d;
  result_t out_q;

  assign in_vertex.x = coord_x_i;
  assign in_vertex.y = coord_y_i;
  assign in_vertex.z = coord_z_i;

  mvdi_seq #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_vertex_i(in_vertex),
    .rd_en_o    (rd_en),
    .rd_addr_o  (rd_addr),
    .rd_data_i  (rd_data),
    .wr_en_o    (wr_en),
    .wr_addr_o  (wr_addr),
    .wr_data_o  (wr_data),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_o      (res)
  );

  mvdi_table #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk_i    (clk_i),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data)
  );

  assign res_ready = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign vertex_index_o  = out_q.vertex_index;
  assign is_new_o        = out_q.is_new;
  assign corner_o        = out_q.corner;
  assign triangle_done_o = out_q.triangle_done;
  assign table_full_o    = out_q.table_full;

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for mesh_vertex_dedup_indexer: streams vertex requests,
// predicts the welded index of each one and checks every result in order.
// Depends on mvdi_pkg and the indexer RTL.
module tb_top;
  import mvdi_pkg::*;

  localparam int unsigned DEPTH       = TABLE_DEPTH_DEF;
  localparam int unsigned STALL_LIMIT = 20000;
  localparam int unsigned RANDOM_HALF = 300;
  localparam int unsigned TAIL_ITEMS  = 184;

  logic                 clk_i     = 1'b0;
  logic                 rst_ni    = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  logic [COORD_W-1:0]   coord_x   = '0;
  logic [COORD_W-1:0]   coord_y   = '0;
  logic [COORD_W-1:0]   coord_z   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [IDX_OUT_W-1:0] vertex_index;
  logic                 is_new;
  logic [CORNER_W-1:0]  corner;
  logic                 triangle_done;
  logic                 table_full;

  vertex_t queued_vertices[$];
  vertex_t issued_pool[$];
  result_t awaited_results[$];

  vertex_t             weld_table [DEPTH];
  int unsigned         weld_count     = 0;
  logic [CORNER_W-1:0] corner_pos     = CORNER_FIRST;
  int unsigned         send_idle_pct  = 0;
  int unsigned         recv_idle_pct  = 0;
  int unsigned         mismatch_count = 0;
  int unsigned         stall_cycles   = 0;

  mesh_vertex_dedup_indexer #(
    .TABLE_DEPTH(DEPTH)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .coord_x_i      (coord_x),
    .coord_y_i      (coord_y),
    .coord_z_i      (coord_z),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .vertex_index_o (vertex_index),
    .is_new_o       (is_new),
    .corner_o       (corner),
    .triangle_done_o(triangle_done),
    .table_full_o   (table_full)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic weld_vertex(input vertex_t v, output result_t r);
    bit          hit;
    int unsigned where;
    hit   = 1'b0;
    where = 0;
    for (int unsigned i = 0; i < weld_count; i++) begin
      if (!hit && weld_table[i] == v) begin
        hit   = 1'b1;
        where = i;
      end
    end
    r = '0;
    if (hit) begin
      r.vertex_index = IDX_OUT_W'(where);
    end else if (weld_count < DEPTH) begin
      weld_table[weld_count] = v;
      r.vertex_index = IDX_OUT_W'(weld_count);
      r.is_new       = 1'b1;
      weld_count++;
    end else begin
      r.vertex_index = IDX_OUT_W'(DEPTH - 1);
      r.table_full   = 1'b1;
    end
    r.corner        = corner_pos;
    r.triangle_done = (corner_pos == CORNER_LAST);
    corner_pos = (corner_pos == CORNER_LAST) ? CORNER_FIRST : corner_pos + 1'b1;
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  function automatic vertex_t rand_vertex();
    return vertex_t'({$urandom, $urandom, $urandom});
  endfunction

  function automatic bit in_pool(input vertex_t v);
    bit seen;
    seen = 1'b0;
    foreach (issued_pool[i]) begin
      if (issued_pool[i] == v) seen = 1'b1;
    end
    return seen;
  endfunction

  function automatic vertex_t pick_known(input bit early_only);
    int unsigned hi;
    hi = issued_pool.size() - 1;
    if (early_only && hi > 63) hi = 63;
    return issued_pool[$urandom_range(hi)];
  endfunction

  // The pool mirrors the table in insertion order, so repeats can name real entries.
  task automatic add_vertex(input vertex_t v);
    if (issued_pool.size() < DEPTH && !in_pool(v)) issued_pool = {issued_pool, v};
    queued_vertices = {queued_vertices, v};
  endtask

  task automatic queue_mixed(input int unsigned n);
    vertex_t     v;
    int unsigned roll;
    for (int unsigned k = 0; k < n; k++) begin
      roll = $urandom_range(99);
      if (roll < 50) begin
        v = rand_vertex();
      end else if (roll < 58) begin
        v = pick_known(1'b0);
        v = v ^ vertex_t'(96'd1 << $urandom_range(95));
      end else if (roll < 65) begin
        v = pick_known(1'b0);
        v = vertex_t'({v.y, v.x, v.z});
      end else if (roll < 85) begin
        v = pick_known(1'b1);
      end else begin
        v = pick_known(1'b0);
      end
      add_vertex(v);
    end
  endtask

  task automatic wait_for_drain();
    do @(negedge clk_i);
    while (queued_vertices.size() != 0 || in_valid || awaited_results.size() != 0);
  endtask

  always @(posedge clk_i) begin
    result_t r;
    vertex_t v;
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        weld_vertex(vertex_t'({coord_x, coord_y, coord_z}), r);
        awaited_results = {awaited_results, r};
      end
      if (!in_valid || in_ready) begin
        if (queued_vertices.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          v = queued_vertices.pop_front();
          in_valid <= 1'b1;
          coord_x  <= v.x;
          coord_y  <= v.y;
          coord_z  <= v.z;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    result_t want;
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          $error("Result with no request outstanding: vertex_index %0d", vertex_index);
          mismatch_count++;
        end else begin
          want = awaited_results.pop_front();
          check_field("vertex_index", 32'(want.vertex_index), 32'(vertex_index));
          check_field("is_new", 32'(want.is_new), 32'(is_new));
          check_field("corner", 32'(want.corner), 32'(corner));
          check_field("triangle_done", 32'(want.triangle_done), 32'(triangle_done));
          check_field("table_full", 32'(want.table_full), 32'(table_full));
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    send_idle_pct = 6;
    recv_idle_pct = 82;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    add_vertex(vertex_t'({32'h0000_0000, 32'h0000_0000, 32'h0000_0000}));
    add_vertex(vertex_t'({32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}));
    add_vertex(vertex_t'({32'h0000_0000, 32'h0000_0000, 32'h0000_0000}));
    add_vertex(vertex_t'({32'h0000_0001, 32'h0000_0000, 32'h0000_0000}));
    add_vertex(vertex_t'({32'h0000_0000, 32'h0000_0001, 32'h0000_0000}));
    add_vertex(vertex_t'({32'h0000_0000, 32'h0000_0000, 32'h0000_0001}));
    add_vertex(vertex_t'({32'h8000_0000, 32'h0000_0000, 32'h0000_0000}));
    add_vertex(vertex_t'({32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFE}));
    add_vertex(vertex_t'({32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}));
    add_vertex(vertex_t'({32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'h0000_0000}));
    add_vertex(vertex_t'({32'h5A5A_5A5A, 32'hA5A5_A5A5, 32'h0000_0000}));
    add_vertex(vertex_t'({32'h0000_0000, 32'hA5A5_A5A5, 32'h5A5A_5A5A}));
    add_vertex(vertex_t'({32'h0000_0001, 32'h0000_0000, 32'h0000_0000}));
    add_vertex(vertex_t'({32'h0000_0001, 32'h0000_0000, 32'h0000_0000}));
    add_vertex(vertex_t'({32'h0000_0001, 32'h0000_0000, 32'h0000_0000}));
    add_vertex(vertex_t'({32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF}));
    queue_mixed(RANDOM_HALF);
    wait_for_drain();

    send_idle_pct = 82;
    recv_idle_pct = 6;
    queue_mixed(RANDOM_HALF);
    wait_for_drain();

    // Neither side idles for the last stretch.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_mixed(TAIL_ITEMS);
    wait_for_drain();

    repeat (DEPTH + 16) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
